/* sv/best_window_hamming_match3_assert.svh */
// assertion macros shared by the best_window_hamming_match3 checkers
// expects signals clk and rst in the scope of every use
`ifndef BEST_WINDOW_HAMMING_MATCH3_ASSERT_SVH
`define BEST_WINDOW_HAMMING_MATCH3_ASSERT_SVH

// same-cycle implication
`define BWHM_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bwhm assertion failed");

// next-cycle implication
`define BWHM_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bwhm assertion failed");

`endif

/* sv/bwhm_pkg.sv */
// shared constants, beat types and pipeline control token of the
// window match search; no dependencies
package bwhm_pkg;

  localparam int MAX_QUERY     = 64;
  localparam int MAX_REFERENCE = 1024;
  localparam int NUM_REFS      = 3;

  localparam int SYM_W   = 8;
  localparam int GID_W   = 2;
  localparam int COUNT_W = 7;
  localparam int REF_W   = $clog2(MAX_REFERENCE + 1);

  // popcount tree shape
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (MAX_QUERY + GROUP - 1) / GROUP;
  localparam int GSUM_W     = $clog2(GROUP + 1);

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_REF   = 1'b1;

  localparam logic [GID_W-1:0] LAST_GID = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN_DIFF = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic             func;
    logic [GID_W-1:0] genome_id;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] best_count_a;
    logic [COUNT_W-1:0] best_count_b;
    logic [COUNT_W-1:0] best_count_c;
    logic [COUNT_W-1:0] query_length;
    logic [2:0]         winner_mask;
    logic [1:0]         status;
  } result_t;

  // travels beside the match bits down the count pipeline
  typedef struct packed {
    logic               score;
    logic               clr_one;
    logic               clr_all;
    logic               emit;
    logic [GID_W-1:0]   gid;
    status_t            status;
    logic [COUNT_W-1:0] qlen;
  } ctl_t;

endpackage

/* sv/bwhm_cell.sv */
// one position of the window: a query byte, a reference byte and the
// registered equality of the two; uses bwhm_pkg
module bwhm_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load_q,
  input  logic                     shift_w,
  input  logic                     en,
  input  logic [bwhm_pkg::SYM_W-1:0] q_in,
  input  logic [bwhm_pkg::SYM_W-1:0] w_in,
  output logic [bwhm_pkg::SYM_W-1:0] q,
  output logic [bwhm_pkg::SYM_W-1:0] w,
  output logic                     match
);
  import bwhm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else if (shift_w) begin
      w <= w_in;
    end
  end

  // compare against the byte arriving this beat, so match lines up with w
  always_ff @(posedge clk) begin
    if (load_q) begin
      q <= q_in;
    end
    if (shift_w) begin
      match <= en && (q == w_in);
    end
  end

endmodule

/* sv/bwhm_popcount.sv */
// two-stage registered count of the match bits of the cell row
// uses bwhm_pkg
module bwhm_popcount (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [bwhm_pkg::MAX_QUERY-1:0] bits,
  output logic [bwhm_pkg::COUNT_W-1:0]   total
);
  import bwhm_pkg::*;

  logic [GSUM_W-1:0]  gsum      [NUM_GROUPS];
  logic [GSUM_W-1:0]  gsum_next [NUM_GROUPS];
  logic [COUNT_W-1:0] total_next;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gsum_next[g] = '0;
      for (int b = 0; b < GROUP; b++) begin
        if (g * GROUP + b < MAX_QUERY) begin
          gsum_next[g] = gsum_next[g] + GSUM_W'(bits[g * GROUP + b]);
        end
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total_next = total_next + COUNT_W'(gsum[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gsum  <= gsum_next;
      total <= total_next;
    end
  end

endmodule

/* sv/best_window_hamming_match3.sv */
// A result beat is registered once the last reference-2 symbol has left the count pipeline.
// Throughput: one symbol per cycle when item_stall is low; reference beats shift the cell row and
// compare, and the match count goes through a two-stage popcount before the best-count update.
// item_stall rises only while a result leaves the count pipeline and the held result is stalled.
// Reset (rst, synchronous) clears counters, flags, best counts, window bytes and the pipeline
// valid bits; query bytes, match bits and the pipeline data are not reset.
module best_window_hamming_match3 (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bwhm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bwhm_pkg::result_t result
);
  import bwhm_pkg::*;

  logic               move;
  logic               accept;
  logic               is_query;
  logic               is_ref;
  logic               load_q;
  logic               shift_w;

  logic [COUNT_W-1:0] query_count, query_count_next;
  logic               overflow_flag, overflow_flag_next;
  logic               query_closed, query_closed_next;
  logic [REF_W-1:0]   window_fill, window_fill_next;
  logic [REF_W-1:0]   ref_len      [NUM_REFS];
  logic [REF_W-1:0]   ref_len_next [NUM_REFS];
  logic [COUNT_W-1:0] best         [NUM_REFS];
  logic [COUNT_W-1:0] best_next    [NUM_REFS];

  ctl_t               ctl_next;
  logic               tok_next;
  ctl_t               c1, c2, c3;
  logic               v1, v2, v3;

  logic [SYM_W-1:0]   q_chain [MAX_QUERY];
  logic [SYM_W-1:0]   w_chain [MAX_QUERY];
  logic [MAX_QUERY-1:0] match;
  logic [COUNT_W-1:0] total;

  logic [COUNT_W-1:0] top;
  result_t            result_next;

  assign move     = !(v3 && c3.emit && result_valid && result_stall);
  assign item_stall = !move;
  assign accept   = item_valid && move;
  assign is_query = (item.func == FUNC_QUERY);
  assign is_ref   = (item.func == FUNC_REF) && (item.genome_id <= LAST_GID);
  assign shift_w  = accept && is_ref;
  assign load_q   = accept && is_query &&
                    ((query_closed ? '0 : query_count) < COUNT_W'(MAX_QUERY));

  // cell row: query bytes and window bytes both enter at cell 0
  for (genvar m = 0; m < MAX_QUERY; m++) begin : g_cell
    logic [SYM_W-1:0] q_src, w_src;
    if (m == 0) begin : g_head
      assign q_src = item.symbol;
      assign w_src = item.symbol;
    end else begin : g_body
      assign q_src = q_chain[m-1];
      assign w_src = w_chain[m-1];
    end
    bwhm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .load_q  (load_q),
      .shift_w (shift_w),
      .en      (COUNT_W'(m) < query_count),
      .q_in    (q_src),
      .w_in    (w_src),
      .q       (q_chain[m]),
      .w       (w_chain[m]),
      .match   (match[m])
    );
  end

  bwhm_popcount u_popcount (
    .clk   (clk),
    .adv   (move),
    .bits  (match),
    .total (total)
  );

  // front: counters, lengths and the control token of this beat
  always_comb begin
    logic [REF_W-1:0]   wf_inc;
    logic [COUNT_W-1:0] qc_base;
    query_count_next   = query_count;
    overflow_flag_next = overflow_flag;
    query_closed_next  = query_closed;
    window_fill_next   = window_fill;
    ref_len_next       = ref_len;
    ctl_next           = '0;
    ctl_next.qlen      = query_count;
    tok_next           = 1'b0;
    qc_base            = query_count;
    wf_inc = (window_fill < REF_W'(MAX_REFERENCE)) ? window_fill + 1'b1 : window_fill;
    if (is_query) begin
      if (query_closed) begin
        // a new query drops everything from the previous search
        qc_base            = '0;
        overflow_flag_next = 1'b0;
        query_closed_next  = 1'b0;
        window_fill_next   = '0;
        for (int r = 0; r < NUM_REFS; r++) ref_len_next[r] = '0;
        ctl_next.clr_all   = 1'b1;
        tok_next           = 1'b1;
      end
      if (qc_base < COUNT_W'(MAX_QUERY)) begin
        query_count_next = qc_base + 1'b1;
      end else begin
        query_count_next   = qc_base;
        overflow_flag_next = 1'b1;
      end
      if (item.last) query_closed_next = 1'b1;
    end else if (is_ref) begin
      tok_next          = 1'b1;
      ctl_next.gid      = item.genome_id;
      ctl_next.clr_one  = (window_fill == '0);
      window_fill_next  = wf_inc;
      ref_len_next[item.genome_id] = wf_inc;
      ctl_next.score    = (query_count != '0) && (wf_inc >= REF_W'(query_count));
      if (item.last) begin
        window_fill_next = '0;
        if (item.genome_id == LAST_GID) begin
          ctl_next.emit = 1'b1;
          if (ref_len_next[0] != ref_len_next[1] || ref_len_next[0] != ref_len_next[2]) begin
            ctl_next.status = ST_LEN_DIFF;
          end else if (REF_W'(query_count) > ref_len_next[0]) begin
            ctl_next.status = ST_TOO_LONG;
          end else if (overflow_flag) begin
            ctl_next.status = ST_OVERFLOW;
          end else begin
            ctl_next.status = ST_OK;
          end
          for (int r = 0; r < NUM_REFS; r++) ref_len_next[r] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_count   <= '0;
      overflow_flag <= 1'b0;
      query_closed  <= 1'b0;
      window_fill   <= '0;
      for (int r = 0; r < NUM_REFS; r++) ref_len[r] <= '0;
    end else if (accept) begin
      query_count   <= query_count_next;
      overflow_flag <= overflow_flag_next;
      query_closed  <= query_closed_next;
      window_fill   <= window_fill_next;
      ref_len       <= ref_len_next;
    end
  end

  // token stages line up with match bits, group sums and total
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (move) begin
      v1 <= accept && tok_next;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      c1 <= ctl_next;
      c2 <= c1;
      c3 <= c2;
    end
  end

  // back: best-count update and result build
  always_comb begin
    best_next = best;
    if (c3.clr_all) begin
      for (int r = 0; r < NUM_REFS; r++) best_next[r] = '0;
    end
    if (c3.clr_one) best_next[c3.gid] = '0;
    if (c3.score && total > best_next[c3.gid]) best_next[c3.gid] = total;

    top = best_next[0];
    for (int r = 1; r < NUM_REFS; r++) begin
      if (best_next[r] > top) top = best_next[r];
    end

    result_next              = '0;
    result_next.query_length = c3.qlen;
    result_next.status       = c3.status;
    if (c3.status == ST_OK) begin
      result_next.best_count_a = best_next[0];
      result_next.best_count_b = best_next[1];
      result_next.best_count_c = best_next[2];
      for (int r = 0; r < NUM_REFS; r++) begin
        result_next.winner_mask[r] = (best_next[r] == top);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REFS; r++) best[r] <= '0;
    end else if (move && v3) begin
      if (c3.emit) begin
        for (int r = 0; r < NUM_REFS; r++) best[r] <= '0;
      end else begin
        best <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move && v3 && c3.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move && v3 && c3.emit) begin
      result <= result_next;
    end
  end

endmodule

/* sv/bwhm_checker.sv */
// port-level checks of best_window_hamming_match3 and the bind that attaches them
// uses bwhm_pkg and best_window_hamming_match3_assert.svh
`include "best_window_hamming_match3_assert.svh"

module bwhm_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input bwhm_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input bwhm_pkg::result_t result
);
  import bwhm_pkg::*;

  // an error beat carries no counts and no winners
  `BWHM_ASSERT_IMP(a_error_zero, result_valid && (result.status != ST_OK),
    (result.best_count_a == '0) && (result.best_count_b == '0) &&
    (result.best_count_c == '0) && (result.winner_mask == '0))

  // no best count exceeds the query length, and the query length stays within MAX_QUERY
  `BWHM_ASSERT_IMP(a_count_bound, result_valid,
    (result.best_count_a <= result.query_length) &&
    (result.best_count_b <= result.query_length) &&
    (result.best_count_c <= result.query_length) &&
    (result.query_length <= COUNT_W'(MAX_QUERY)))

  // reference 0 wins exactly when it reaches the top count
  `BWHM_ASSERT_IMP(a_mask_a, result_valid && (result.status == ST_OK),
    result.winner_mask[0] == ((result.best_count_a >= result.best_count_b) &&
                              (result.best_count_a >= result.best_count_c)))

  // a stalled result beat holds
  `BWHM_ASSERT_NXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(result))

  // a stalled input beat holds
  `BWHM_ASSERT_NXT(a_item_hold, item_valid && item_stall,
    item_valid && $stable(item))

endmodule

bind best_window_hamming_match3 bwhm_checker u_bwhm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
